@@ rtl/ifsi_pkg.sv @@
package ifsi_pkg;

   localparam logic [7:0] HEADER_BYTE = 8'h55;

   // deframer phase codes
   localparam int PHASE_W = 4;
   localparam logic [PHASE_W-1:0] PHASE_HUNT = 4'd0;
   localparam logic [PHASE_W-1:0] PHASE_TYPE = 4'd1;
   localparam logic [PHASE_W-1:0] PHASE_PAY0 = 4'd2;
   localparam logic [PHASE_W-1:0] PHASE_LAST = 4'd10;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_CODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAK       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN       = 2'd2;
   localparam int CSR_DATA_W = 32;

   localparam int LEAK_W  = 25;
   localparam int GAIN_W  = 32;
   localparam int SPEED_W = 48;
   localparam int MAG_W   = 16;

   localparam logic [7:0]        ACCEL_CODE_RST = 8'd81;
   localparam logic [LEAK_W-1:0] LEAK_RST       = 25'd16777216;
   localparam logic [GAIN_W-1:0] GAIN_RST       = 32'd102845;

   // result layout: type, four words, is_accel, magnitude, speed
   localparam int RSP_BITS   = 8 + 64 + 1 + MAG_W + SPEED_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic        is_accel;
      logic [63:0] payload;
      logic [7:0]  frame_type;
   } frame_rec_type;

endpackage

@@ rtl/ifsi_front.sv @@
module ifsi_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic [7:0]            accel_code,
   input  logic                  q_full,
   output logic                  q_push,
   output ifsi_pkg::frame_rec_type q_rec
);

   logic [ifsi_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [7:0]                   type_ff, type_in;
   logic [63:0]                  payload_ff, payload_in;
   logic                         accept;
   logic [2:0]                   byte_sel;

   // only the checksum byte needs room in the queue
   assign req_tready = !((phase_ff == ifsi_pkg::PHASE_LAST) && q_full);
   assign accept     = req_tvalid && req_tready;
   assign byte_sel   = 3'(phase_ff - ifsi_pkg::PHASE_PAY0);

   always_comb begin
      phase_in   = phase_ff;
      type_in    = type_ff;
      payload_in = payload_ff;
      if (accept) begin
         if ((phase_ff == ifsi_pkg::PHASE_HUNT) || (phase_ff > ifsi_pkg::PHASE_LAST)) begin
            phase_in = (req_tdata == ifsi_pkg::HEADER_BYTE) ? ifsi_pkg::PHASE_TYPE
                                                           : ifsi_pkg::PHASE_HUNT;
         end else if (phase_ff == ifsi_pkg::PHASE_TYPE) begin
            type_in  = req_tdata;
            phase_in = ifsi_pkg::PHASE_PAY0;
         end else if (phase_ff < ifsi_pkg::PHASE_LAST) begin
            payload_in[{byte_sel, 3'b000} +: 8] = req_tdata;
            phase_in = phase_ff + 4'd1;
         end else begin
            // checksum byte, value ignored
            phase_in = ifsi_pkg::PHASE_HUNT;
         end
      end
   end

   assign q_push           = accept && (phase_ff == ifsi_pkg::PHASE_LAST);
   assign q_rec.frame_type = type_ff;
   assign q_rec.payload    = payload_ff;
   assign q_rec.is_accel   = (type_ff == accel_code);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ifsi_pkg::PHASE_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff    <= type_in;
      payload_ff <= payload_in;
   end

endmodule

@@ rtl/ifsi_queue.sv @@
module ifsi_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_push,
   input  ifsi_pkg::frame_rec_type q_rec,
   output logic                    q_full,
   input  logic                    q_pop,
   output logic                    q_valid,
   output ifsi_pkg::frame_rec_type q_head
);

   ifsi_pkg::frame_rec_type entry_ff [ifsi_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign q_full  = (count_ff == 2'(ifsi_pkg::QUEUE_DEPTH));
   assign q_valid = (count_ff != 2'd0);
   assign q_head  = entry_ff[rd_ptr_ff];
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_rec;
      end
   end

endmodule

@@ rtl/ifsi_back.sv @@
module ifsi_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  ifsi_pkg::frame_rec_type             q_head,
   output logic                                q_pop,
   input  logic [ifsi_pkg::LEAK_W-1:0]         leak_factor,
   input  logic [ifsi_pkg::GAIN_W-1:0]         step_gain,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ifsi_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // sequencer steps; the multiplier is shared across the first six
   localparam logic [4:0] STEP_XX    = 5'd0;
   localparam logic [4:0] STEP_YY    = 5'd1;
   localparam logic [4:0] STEP_ZZ    = 5'd2;
   localparam logic [4:0] STEP_SLO   = 5'd3;
   localparam logic [4:0] STEP_SHI   = 5'd4;
   localparam logic [4:0] STEP_GAIN  = 5'd5;
   localparam logic [4:0] STEP_SAT   = 5'd7;
   localparam logic [4:0] STEP_ROOT0 = 5'd4;
   localparam logic [4:0] STEP_END   = 5'd19;

   localparam int ACC_W = 51;
   localparam logic signed [ACC_W-1:0] ACC_MAX = {4'b0000, {47{1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {4'b1111, 47'd0};

   logic [1:0]                    state_ff, state_in;
   logic [4:0]                    cnt_ff, cnt_in;
   ifsi_pkg::frame_rec_type       rec_ff, rec_in;
   logic signed [58:0]            prod_ff;
   logic [31:0]                   sumsq_ff, sumsq_in;
   logic [15:0]                   rem_ff, rem_in;
   logic [15:0]                   root_ff, root_in;
   logic [24:0]                   lo_ff, lo_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [ifsi_pkg::SPEED_W-1:0] speed_ff, speed_in;
   logic signed [ifsi_pkg::SPEED_W-1:0] new_speed_ff, new_speed_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ifsi_pkg::RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic signed [32:0] mul_a;
   logic signed [25:0] mul_b;
   logic signed [58:0] mul_p;
   logic [15:0]        wx, wy, wz;
   logic [17:0]        rem_next, trial;
   logic               out_free;

   assign wx = rec_ff.payload[15:0];
   assign wy = rec_ff.payload[31:16];
   assign wz = rec_ff.payload[47:32];

   always_comb begin
      case (cnt_ff)
         STEP_XX: begin
            mul_a = {{17{wx[15]}}, wx};
            mul_b = {{10{wx[15]}}, wx};
         end
         STEP_YY: begin
            mul_a = {{17{wy[15]}}, wy};
            mul_b = {{10{wy[15]}}, wy};
         end
         STEP_ZZ: begin
            mul_a = {{17{wz[15]}}, wz};
            mul_b = {{10{wz[15]}}, wz};
         end
         STEP_SLO: begin
            mul_a = {9'd0, speed_ff[23:0]};
            mul_b = {1'b0, leak_factor};
         end
         STEP_SHI: begin
            mul_a = {{9{speed_ff[47]}}, speed_ff[47:24]};
            mul_b = {1'b0, leak_factor};
         end
         STEP_GAIN: begin
            mul_a = {1'b0, step_gain};
            mul_b = {{10{wy[15]}}, wy};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // one result bit per cycle of the square root
   assign rem_next = {rem_ff, sumsq_ff[31:30]};
   assign trial    = {root_ff, 2'b01};
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rec_in       = rec_ff;
      sumsq_in     = sumsq_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      lo_in        = lo_ff;
      acc_in       = acc_ff;
      new_speed_in = new_speed_ff;
      speed_in     = speed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               rec_in   = q_head;
               cnt_in   = STEP_XX;
               rem_in   = '0;
               root_in  = '0;
               state_in = q_head.is_accel ? ST_RUN : ST_DONE;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 5'd1;
            // product of step n is in prod_ff during step n+1
            if (cnt_ff == STEP_YY) begin
               sumsq_in = prod_ff[31:0];
            end else if ((cnt_ff == STEP_ZZ) || (cnt_ff == STEP_SLO)) begin
               sumsq_in = sumsq_ff + prod_ff[31:0];
            end
            if (cnt_ff == STEP_SHI) begin
               lo_in = prod_ff[48:24];
            end
            if (cnt_ff == STEP_GAIN) begin
               acc_in = prod_ff[ACC_W-1:0] + {26'd0, lo_ff};
            end
            if (cnt_ff == STEP_GAIN + 5'd1) begin
               acc_in = acc_ff + prod_ff[ACC_W-1:0];
            end
            if (cnt_ff == STEP_SAT) begin
               if (acc_ff > ACC_MAX) begin
                  new_speed_in = ACC_MAX[ifsi_pkg::SPEED_W-1:0];
               end else if (acc_ff < ACC_MIN) begin
                  new_speed_in = ACC_MIN[ifsi_pkg::SPEED_W-1:0];
               end else begin
                  new_speed_in = acc_ff[ifsi_pkg::SPEED_W-1:0];
               end
            end
            if (cnt_ff >= STEP_ROOT0) begin
               sumsq_in = {sumsq_ff[29:0], 2'b00};
               if (rem_next >= trial) begin
                  rem_in  = 16'(rem_next - trial);
                  root_in = {root_ff[14:0], 1'b1};
               end else begin
                  rem_in  = rem_next[15:0];
                  root_in = {root_ff[14:0], 1'b0};
               end
            end
            if (cnt_ff == STEP_END) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (rec_ff.is_accel) begin
                  speed_in    = new_speed_ff;
                  rsp_data_in = {new_speed_ff, root_ff, 1'b1, rec_ff.payload,
                                 rec_ff.frame_type};
               end else begin
                  rsp_data_in = {speed_ff, 16'd0, 1'b0, rec_ff.payload,
                                 rec_ff.frame_type};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         speed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         speed_ff     <= speed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      rec_ff       <= rec_in;
      prod_ff      <= mul_p;
      sumsq_ff     <= sumsq_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      lo_ff        <= lo_in;
      acc_ff       <= acc_in;
      new_speed_ff <= new_speed_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(ifsi_pkg::RSP_DATA_W - ifsi_pkg::RSP_BITS)'(0), rsp_data_ff};

endmodule

@@ rtl/imu_frame_deframer_speed_integrator.sv @@
// IMU serial frame deframer with acceleration magnitude and speed integrator.
// req_ channel: one received byte per transaction. The front hunts for the
// header byte 0x55, then takes a type byte, eight payload bytes and a
// checksum byte (not checked). It takes one byte per cycle unless the queue is full at a checksum byte.
// rsp_ channel: one transaction per completed frame, carrying the type, the
// four payload words, the acceleration flag, the root of the summed axis
// squares and the integrated speed (saturating, 48 bits signed).
// csr_ port: write-only; index 0 acceleration type code, 1 leak factor
// (Q1.24), 2 step gain. Write only while the block is idle.
// An acceleration frame passes from the queue through the back end's idle
// state, its sequencer steps (shared multiplier steps, saturation and the
// one-bit-per-cycle square root) and its done state; other frames skip the
// steps. The back end takes a new frame only once it is through with the last.
// A two-entry frame queue sits between front and back. Reset clears the phase,
// the queue, the speed and the registers to their defaults. When the receiver
// stalls, the result is held, the back end waits, and once the queue is full
// req_tready drops on a checksum byte.
module imu_frame_deframer_speed_integrator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] rx_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] frame_type, [23:8] word_zero, [39:24] word_one, [55:40] word_two,
   // [71:56] word_three, [72] is_accel, [88:73] accel_magnitude, [136:89] speed
   output logic [ifsi_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [ifsi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ifsi_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [7:0]                    accel_code_ff;
   logic [ifsi_pkg::LEAK_W-1:0]   leak_ff;
   logic [ifsi_pkg::GAIN_W-1:0]   gain_ff;

   logic                    q_push, q_full, q_pop, q_valid;
   ifsi_pkg::frame_rec_type q_rec, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_code_ff <= ifsi_pkg::ACCEL_CODE_RST;
         leak_ff       <= ifsi_pkg::LEAK_RST;
         gain_ff       <= ifsi_pkg::GAIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            ifsi_pkg::CSR_ACCEL_CODE: accel_code_ff <= csr_wdata[7:0];
            ifsi_pkg::CSR_LEAK:       leak_ff       <= csr_wdata[ifsi_pkg::LEAK_W-1:0];
            ifsi_pkg::CSR_GAIN:       gain_ff       <= csr_wdata[ifsi_pkg::GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ifsi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .accel_code (accel_code_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_rec      (q_rec)
   );

   ifsi_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_rec   (q_rec),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_valid (q_valid),
      .q_head  (q_head)
   );

   ifsi_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .leak_factor (leak_ff),
      .step_gain   (gain_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("frame pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("frame popped from an empty queue");

   a_mag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[72]) |-> (rsp_tdata[88:73] == 16'd0))
      else $error("nonzero magnitude on a non-acceleration frame");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

@@ verif/imu_frame_deframer_speed_integrator_tb.sv @@
`timescale 1ns / 1ps

module imu_frame_deframer_speed_integrator_tb;

   localparam int     CYCLE_LIMIT   = 500000;
   localparam int     SETTLE_CYCLES = 40;
   localparam int     DRAIN_LIMIT   = 20000;
   localparam int     NUM_PHASES    = 6;
   localparam int     PHASE_FRAMES  = 28;
   localparam int     NUM_ROWS      = 8;
   localparam longint SPEED_HI      = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SPEED_LO      = -SPEED_HI - 1;
   // index with no register behind it
   localparam logic [ifsi_pkg::CSR_IDX_W-1:0] CSR_NONE = 2'd3;

   // same bit order as rsp_tdata, frame_type in the lowest bits
   typedef struct packed {
      logic [ifsi_pkg::SPEED_W-1:0] speed;
      logic [ifsi_pkg::MAG_W-1:0]   magnitude;
      logic                         is_accel;
      logic [15:0]                  word_three;
      logic [15:0]                  word_two;
      logic [15:0]                  word_one;
      logic [15:0]                  word_zero;
      logic [7:0]                   frame_type;
   } frame_result_type;

   typedef struct {
      int          lead;
      logic [7:0]  ftype;
      logic [63:0] payload;
      bit          typed;
      bit          accel;
      logic [15:0] mag;
      longint      spd;
   } frame_row_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [7:0]                      req_tdata;   // [7:0] rx_byte
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   // [7:0] frame_type, [23:8] word_zero, [39:24] word_one, [55:40] word_two,
   // [71:56] word_three, [72] is_accel, [88:73] accel_magnitude, [136:89] speed
   logic [ifsi_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_we;
   logic [ifsi_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ifsi_pkg::CSR_DATA_W-1:0] csr_wdata;

   imu_frame_deframer_speed_integrator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // deframer and integrator state as predicted
   logic [ifsi_pkg::PHASE_W-1:0]        pred_phase;
   logic [7:0]                          pred_type;
   logic [63:0]                         pred_payload;
   logic signed [ifsi_pkg::SPEED_W-1:0] pred_speed;
   logic [7:0]                          cfg_accel_code;
   logic [ifsi_pkg::LEAK_W-1:0]         cfg_leak;
   logic [ifsi_pkg::GAIN_W-1:0]         cfg_gain;

   frame_result_type pending_frames[$];
   frame_result_type want, got;
   frame_row_type    dir_rows [NUM_ROWS];

   int n_errors    = 0;
   int cycle_count = 0;
   int burst_left  = 0;
   int gap_max     = 0;
   int stall_pct   = 0;
   int stall_left  = 0;

   logic [31:0] phase_code [NUM_PHASES] =
      '{32'd81, 32'd0, 32'hABCD_EFFF, 32'h55, 32'd0, 32'd81};
   logic [31:0] phase_leak [NUM_PHASES] =
      '{32'h0100_0000, 32'd0, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'd0, 32'd16700000};
   logic [31:0] phase_gain [NUM_PHASES] =
      '{32'd102845, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 32'd102845};
   int phase_gap   [NUM_PHASES] = '{0, 3, 8, 0, 5, 2};
   int phase_stall [NUM_PHASES] = '{0, 25, 60, 40, 10, 0};

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL imu_frame_deframer_speed_integrator");
         $finish;
      end
   end

   function automatic logic [15:0] floor_root(input longint unsigned v);
      logic [15:0] r;
      logic [15:0] trial;
      r = '0;
      for (int i = 15; i >= 0; i--) begin
         trial = r | (16'd1 << i);
         if (longint'(trial) * longint'(trial) <= v) r = trial;
      end
      return r;
   endfunction

   // advances the predicted deframer by one byte; returns 1 when a frame closes
   function automatic bit deframe_byte(input logic [7:0] b, output frame_result_type res);
      longint ax, ay, az;
      logic signed [95:0] wide;
      res = '0;
      if (pred_phase == ifsi_pkg::PHASE_HUNT || pred_phase > ifsi_pkg::PHASE_LAST) begin
         pred_phase = (b == ifsi_pkg::HEADER_BYTE) ? ifsi_pkg::PHASE_TYPE
                                                   : ifsi_pkg::PHASE_HUNT;
         return 1'b0;
      end
      if (pred_phase == ifsi_pkg::PHASE_TYPE) begin
         pred_type  = b;
         pred_phase = ifsi_pkg::PHASE_PAY0;
         return 1'b0;
      end
      if (pred_phase < ifsi_pkg::PHASE_LAST) begin
         pred_payload[8*(pred_phase-ifsi_pkg::PHASE_PAY0) +: 8] = b;
         pred_phase = pred_phase + 1'b1;
         return 1'b0;
      end
      // checksum byte closes the frame, its value is not used
      pred_phase     = ifsi_pkg::PHASE_HUNT;
      res.frame_type = pred_type;
      res.word_zero  = pred_payload[15:0];
      res.word_one   = pred_payload[31:16];
      res.word_two   = pred_payload[47:32];
      res.word_three = pred_payload[63:48];
      res.is_accel   = (pred_type == cfg_accel_code);
      if (res.is_accel) begin
         ax = longint'($signed(pred_payload[15:0]));
         ay = longint'($signed(pred_payload[31:16]));
         az = longint'($signed(pred_payload[47:32]));
         res.magnitude = floor_root(ax * ax + ay * ay + az * az);
         wide = pred_speed * $signed({1'b0, cfg_leak});
         // arithmetic shift floors toward minus infinity
         wide = (wide >>> 24) + ay * $signed({1'b0, cfg_gain});
         if (wide > SPEED_HI) wide = SPEED_HI;
         else if (wide < SPEED_LO) wide = SPEED_LO;
         pred_speed = wide[ifsi_pkg::SPEED_W-1:0];
      end
      res.speed = pred_speed;
      return 1'b1;
   endfunction

   function automatic logic [7:0] junk_byte();
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255)); while (v == ifsi_pkg::HEADER_BYTE);
      return v;
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return 16'($signed($urandom_range(0, 64)) - 32);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      frame_result_type res;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (req_tready !== 1'b1);
      if (deframe_byte(b, res)) pending_frames.push_back(res);
   endtask

   task automatic send_frame(input int lead, input logic [7:0] ftype,
                             input logic [63:0] payload);
      repeat (lead) send_byte(junk_byte());
      send_byte(ifsi_pkg::HEADER_BYTE);
      send_byte(ftype);
      for (int i = 0; i < 8; i++) send_byte(payload[8*i +: 8]);
      send_byte(8'($urandom_range(0, 255)));
   endtask

   // drop valid, wait for every outstanding frame, then let the back end settle
   task automatic wait_drained(input int extra);
      int guard;
      guard = 0;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_frames.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ifsi_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ifsi_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         ifsi_pkg::CSR_ACCEL_CODE: cfg_accel_code = val[7:0];
         ifsi_pkg::CSR_LEAK:       cfg_leak       = val[ifsi_pkg::LEAK_W-1:0];
         ifsi_pkg::CSR_GAIN:       cfg_gain       = val[ifsi_pkg::GAIN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
         n_errors++;
      end
   endtask

   // receiver stalls on its own schedule, with an occasional long hold
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left = ($urandom_range(0, 19) == 0) ? 40 : $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_frames.size() == 0) begin
            $error("result transaction with no frame outstanding: 0x%0h", rsp_tdata);
            n_errors++;
         end else begin
            want = pending_frames.pop_front();
            got  = rsp_tdata[ifsi_pkg::RSP_BITS-1:0];
            check_field("frame_type", want.frame_type, got.frame_type);
            check_field("word_zero", want.word_zero, got.word_zero);
            check_field("word_one", want.word_one, got.word_one);
            check_field("word_two", want.word_two, got.word_two);
            check_field("word_three", want.word_three, got.word_three);
            check_field("is_accel", want.is_accel, got.is_accel);
            check_field("accel_magnitude", want.magnitude, got.magnitude);
            check_field("speed", want.speed, got.speed);
            check_field("pad", '0, rsp_tdata[ifsi_pkg::RSP_DATA_W-1:ifsi_pkg::RSP_BITS]);
         end
      end
   end

   initial begin
      frame_result_type res;
      logic [7:0]  ftype;
      logic [31:0] code_val, leak_val, gain_val;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      reset      = 1'b1;
      pred_phase     = ifsi_pkg::PHASE_HUNT;
      pred_type      = '0;
      pred_payload   = '0;
      pred_speed     = '0;
      cfg_accel_code = ifsi_pkg::ACCEL_CODE_RST;
      cfg_leak       = ifsi_pkg::LEAK_RST;
      cfg_gain       = ifsi_pkg::GAIN_RST;

      // runs on the reset register values: code 0x51, leak 1.0, gain 102845
      dir_rows = '{
         '{3, ifsi_pkg::ACCEL_CODE_RST, 64'h0, 1'b1, 1'b1, 16'd0, 64'sd0},
         '{0, ifsi_pkg::ACCEL_CODE_RST, 64'h0000_0000_0004_0003, 1'b1, 1'b1, 16'd5,
           64'sd411380},
         // header value as type and in every payload byte
         '{0, ifsi_pkg::HEADER_BYTE, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 16'd0,
           64'sd411380},
         '{0, ifsi_pkg::ACCEL_CODE_RST, 64'h0000_0000_FFFC_0000, 1'b1, 1'b1, 16'd4,
           64'sd0},
         '{1, ifsi_pkg::ACCEL_CODE_RST, 64'h7FFF_8000_8000_8000, 1'b0, 1'b0, 16'd0,
           64'sd0},
         '{0, ifsi_pkg::ACCEL_CODE_RST, 64'h8000_7FFF_7FFF_7FFF, 1'b0, 1'b0, 16'd0,
           64'sd0},
         '{2, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 16'd0, 64'sd0},
         '{0, 8'hFF, 64'h7FFF_8000_0100_0001, 1'b0, 1'b0, 16'd0, 64'sd0}
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      gap_max   = 2;
      stall_pct = 20;
      foreach (dir_rows[r]) begin
         send_frame(dir_rows[r].lead, dir_rows[r].ftype, dir_rows[r].payload);
         if (dir_rows[r].typed) begin
            res = pending_frames.pop_back();
            res.is_accel  = dir_rows[r].accel;
            res.magnitude = dir_rows[r].mag;
            res.speed     = dir_rows[r].spd[ifsi_pkg::SPEED_W-1:0];
            pending_frames.push_back(res);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         // the deframer must sit in the hunting phase before the registers move
         while (pred_phase != ifsi_pkg::PHASE_HUNT) send_byte(junk_byte());
         wait_drained(SETTLE_CYCLES);
         code_val = phase_code[p];
         leak_val = phase_leak[p];
         gain_val = phase_gain[p];
         if (p == 4) begin
            code_val = $urandom_range(0, 255);
            leak_val = $urandom_range(0, 32'h0100_0000);
            gain_val = $urandom;
         end
         if (p == 0) write_reg(CSR_NONE, 32'h1234_5678);
         write_reg(ifsi_pkg::CSR_ACCEL_CODE, code_val);
         write_reg(ifsi_pkg::CSR_LEAK, leak_val);
         write_reg(ifsi_pkg::CSR_GAIN, gain_val);
         @(negedge clock);
         csr_we <= 1'b0;
         gap_max   = phase_gap[p];
         stall_pct = phase_stall[p];

         for (int f = 0; f < PHASE_FRAMES; f++) begin
            // stray bytes; a stray header shifts the framing of what follows
            if ($urandom_range(0, 9) == 0)
               repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
            case ($urandom_range(0, 9))
               0: ftype = ifsi_pkg::HEADER_BYTE;
               1, 2: ftype = 8'($urandom_range(0, 255));
               default: ftype = cfg_accel_code;
            endcase
            send_frame(0, ftype, {pick_word(), pick_word(), pick_word(), pick_word()});
            if (p == 2 && f == 10) wait_drained(0);
         end
      end

      while (pred_phase != ifsi_pkg::PHASE_HUNT) send_byte(junk_byte());
      wait_drained(SETTLE_CYCLES);
      if (pending_frames.size() != 0) begin
         $error("%0d frames never produced a result", pending_frames.size());
         n_errors++;
      end
      if (n_errors == 0) begin
         $display("PASS imu_frame_deframer_speed_integrator");
      end else begin
         $display("FAIL imu_frame_deframer_speed_integrator");
      end
      $finish;
   end

endmodule
